// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the block bitmap allocator.
// Depends on nothing; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

// Expression that must never be true outside reset.
`define BBA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/bba_pkg.sv =====
// Package of the block bitmap allocator: default sizes, request and status codes,
// payload word types. Depends on nothing.
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 32768;
	localparam int FIRST_DATA_DEF = 1034;
	localparam int WORD_BITS_DEF  = 32;

	localparam int ID_W     = 16;
	localparam int GRANT_W  = 15;
	localparam int STATUS_W = 2;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t         req_type;
		logic [ID_W-1:0]   block_id;
	} req_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_block;
		status_t            status;
	} rsp_t;

endpackage

// ===== hw/rtl/bba_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is supplied by the instantiating module (see bba_pkg).
interface bba_stream_if #(
	parameter type payload_t = logic [0:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/block_bitmap_allocator.sv =====
// Next-fit block allocator over a used/free bitmap held in one synchronous RAM.
// Flow: a refused request goes straight to S_DONE; a free passes through S_MOD; an allocate
// passes through S_MOD, then S_SCAN for each further bitmap word scanned (up to MAP_WORDS-1 words).
// Throughput: a new request is taken the cycle after the previous one retires to
// the response register; the scan reads one word per cycle through the single RAM read port.
// Reset: the bitmap is cleared by a pass over all MAP_WORDS words (1024 by default), no requests.
module block_bitmap_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
	parameter int FIRST_DATA = bba_pkg::FIRST_DATA_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF   // power of two, 8 to 64
) (
	input  logic               clk,
	input  logic               arst_n,
	bba_stream_if.sink         req,
	bba_stream_if.source       rsp
);

	`include "assert_macros.svh"

	// ------------------------------------------------------------------
	// Geometry. A block number is {word address, bit in word}.
	// ------------------------------------------------------------------
	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW        = AW + BIT_W;
	// compare width: holds NUM_BLOCKS itself and any 16-bit block id
	localparam int CW        = (HW + 1 > bba_pkg::ID_W) ? HW + 1 : bba_pkg::ID_W + 1;
	localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;

	localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
	// bits of the last word past the end of the disk read as used
	localparam logic [WORD_BITS-1:0] TAIL_USED = ~(ONES >> (WORD_BITS - LAST_BITS));
	localparam logic [BIT_W-1:0]     TOP_BIT   = BIT_W'(WORD_BITS - 1);
	localparam logic                 FULL_AT_RESET = (FIRST_DATA >= NUM_BLOCKS);
	localparam logic [HW-1:0]        HINT_RESET = FULL_AT_RESET ? '0 : HW'(FIRST_DATA);
	localparam logic [CW-1:0]        NUM_BLOCKS_C = CW'(NUM_BLOCKS);

	typedef enum logic [2:0] {
		S_CLR,    // clearing pass after reset
		S_IDLE,   // wait for a request
		S_MOD,    // read data back: modify, write, on allocate look for next free bit
		S_SCAN,   // walk following words, one per cycle
		S_DONE    // hand result to the response register
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       scan_q;
	logic [HW-1:0]       hint_q;
	logic                full_q;
	bba_pkg::req_kind_t  op_q;
	logic [CW-1:0]       id_q;
	bba_pkg::rsp_t       res_q;
	bba_pkg::rsp_t       rsp_pay_q;
	logic                rsp_valid_q;

	// RAM port signals
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	// free-bit search
	logic [WORD_BITS-1:0] find_word;
	logic                 find_hit;
	logic [BIT_W-1:0]     find_idx;

	// decoded request fields
	logic                 accept;
	logic [CW-1:0]        in_id;
	logic                 in_range;
	logic [AW-1:0]        hint_word;
	logic [BIT_W-1:0]     hint_bit;
	logic [AW-1:0]        id_word;
	logic [BIT_W-1:0]     id_bit;
	logic                 load_rsp;
	logic                 id_below_hint;

	assign accept    = req.valid && req.ready;
	assign in_id     = CW'(req.payload.block_id);
	assign in_range  = in_id < NUM_BLOCKS_C;
	assign hint_word = hint_q[HW-1:BIT_W];
	assign hint_bit  = hint_q[BIT_W-1:0];
	assign id_word   = id_q[BIT_W +: AW];
	assign id_bit    = id_q[BIT_W-1:0];
	assign id_below_hint = id_q < CW'(hint_q);

	// Response register frees the core: a new request may come in while
	// the last result still waits on the response channel.
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_pay_q;

	// ------------------------------------------------------------------
	// RAM control and search input.
	// ------------------------------------------------------------------
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = clr_q;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = hint_word;
		find_word = ONES;
		unique case (state_q)
			S_CLR: begin
				// wipe one word per cycle
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				// start the read for the word this request touches
				rd_addr = (req.payload.req_type == bba_pkg::REQ_ALLOC) ? hint_word
					: in_id[BIT_W +: AW];
				rd_en   = accept && ((req.payload.req_type == bba_pkg::REQ_ALLOC)
					? !full_q : in_range);
			end
			S_MOD: begin
				wr_en = 1'b1;
				if (op_q == bba_pkg::REQ_FREE) begin
					wr_addr = id_word;
					wr_data = rd_data & ~(WORD_BITS'(1) << id_bit);
				end else begin
					wr_addr   = hint_word;
					wr_data   = rd_data | (WORD_BITS'(1) << hint_bit);
					// search above the granted bit only
					find_word = wr_data | (ONES >> (TOP_BIT - hint_bit))
						| ((hint_word == LAST_WORD) ? TAIL_USED : '0);
					// prefetch the next word in case this one is exhausted
					rd_en     = (hint_word != LAST_WORD);
					rd_addr   = hint_word + AW'(1);
				end
			end
			S_SCAN: begin
				find_word = rd_data | ((scan_q == LAST_WORD) ? TAIL_USED : '0);
				rd_en     = (scan_q != LAST_WORD);
				rd_addr   = scan_q + AW'(1);
			end
			S_DONE: begin
				// hold: nothing touches the bitmap
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bba_zero_find #(
		.W (WORD_BITS)
	) u_find (
		.word  (find_word),
		.found (find_hit),
		.idx   (find_idx)
	);

	// ------------------------------------------------------------------
	// Sequencer: state, hint, full flag and response register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			scan_q      <= '0;
			hint_q      <= HINT_RESET;
			full_q      <= FULL_AT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= req.payload.req_type;
						id_q <= in_id;
						if (req.payload.req_type == bba_pkg::REQ_ALLOC) begin
							if (full_q) begin
								res_q   <= '{granted_block: '0, status: bba_pkg::STAT_NO_FREE};
								state_q <= S_DONE;
							end else begin
								state_q <= S_MOD;
							end
						end else begin
							if (in_range) begin
								state_q <= S_MOD;
							end else begin
								res_q   <= '{granted_block: '0, status: bba_pkg::STAT_RANGE};
								state_q <= S_DONE;
							end
						end
					end
				end
				S_MOD: begin
					if (op_q == bba_pkg::REQ_FREE) begin
						res_q <= '{granted_block: '0, status: bba_pkg::STAT_OK};
						// lower the hint, and leave the full condition
						if (full_q || id_below_hint) begin
							hint_q <= id_q[HW-1:0];
							full_q <= 1'b0;
						end
						state_q <= S_DONE;
					end else begin
						res_q <= '{granted_block: bba_pkg::GRANT_W'(hint_q),
							status: bba_pkg::STAT_OK};
						if (find_hit) begin
							hint_q  <= {hint_word, find_idx};
							state_q <= S_DONE;
						end else if (hint_word == LAST_WORD) begin
							full_q  <= 1'b1;
							state_q <= S_DONE;
						end else begin
							scan_q  <= hint_word + AW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (find_hit) begin
						hint_q  <= {scan_q, find_idx};
						state_q <= S_DONE;
					end else if (scan_q == LAST_WORD) begin
						full_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						// advance to the word prefetched this cycle
						scan_q <= scan_q + AW'(1);
					end
				end
				S_DONE: begin
					if (load_rsp) begin
						rsp_pay_q <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// a live hint always names a real block
	`BBA_ASSERT(a_hint_in_range, clk, arst_n, !full_q |-> (CW'(hint_q) < NUM_BLOCKS_C))
	// the scan only ever walks above the word of the granted block
	`BBA_ASSERT(a_scan_above_hint, clk, arst_n, (state_q == S_SCAN) |-> (scan_q > hint_word))
	// a new result never overwrites one still waiting on the response side
	`BBA_ASSERT_NEVER(a_no_rsp_overrun, clk, arst_n, load_rsp && rsp_valid_q && !rsp.ready)
	// a free request never reports a granted block
	`BBA_ASSERT(a_free_no_grant, clk, arst_n,
		(load_rsp && (op_q == bba_pkg::REQ_FREE)) |=> (rsp_pay_q.granted_block == '0))

endmodule

// ===== hw/rtl/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bba_zero_find.sv =====
// Lowest-clear-bit finder for one bitmap word: isolate, then one-hot encode.
// Depends on nothing.
module bba_zero_find #(
	parameter int W = 32,
	localparam int IW = $clog2(W)
) (
	input  logic [W-1:0]  word,
	output logic          found,
	output logic [IW-1:0] idx
);

	logic [W-1:0] free_bits;
	logic [W-1:0] lowest;

	// two's complement trick keeps only the lowest set bit
	assign free_bits = ~word;
	assign lowest    = free_bits & (~free_bits + W'(1));
	assign found     = |free_bits;

	always_comb begin
		for (int b = 0; b < IW; b++) begin
			idx[b] = 1'b0;
			for (int i = 0; i < W; i++) begin
				if (((i >> b) & 1) == 1) begin
					idx[b] = idx[b] | lowest[i];
				end
			end
		end
	end

endmodule
